### hw/rtl/tzc_pkg.sv
`timescale 1ns / 1ps

package tzc_pkg;

   localparam int COORD_W = 16;   // vertex coordinate width
   localparam int GRID_W  = 12;   // point coordinate port width
   localparam int SLOT_W  = 4;
   localparam int CNT_W   = 5;
   localparam int DIFF_W  = 17;   // difference of two coordinates
   localparam int PDIFF_W = 18;   // point minus vertex
   localparam int PROD_W  = DIFF_W + PDIFF_W;
   localparam int SUM_W   = PROD_W + 3;

   typedef enum logic {
      REQ_LOAD  = 1'b0,
      REQ_QUERY = 1'b1
   } req_kind_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] x;
   } vertex_type;

   typedef struct packed {
      vertex_type third;
      vertex_type second;
      vertex_type first;
   } row_type;

   typedef struct packed {
      logic busy;      // any triangle still in the pipeline
      logic hit_vld;
      logic hit;
   } test_status_type;

endpackage

### hw/rtl/triangle_zone_coverage_test.sv
`timescale 1ns / 1ps

// Load: written at the accepting edge; busy stays low.
// Query: reads n = min(triangle_count, NUM_TRIANGLES) table rows, one row per cycle, and
//   each row runs through a four-stage sign-test pipeline; busy stays high until the last
//   row has left it, and rsp_valid strobes in the first cycle in which busy is low again.
// The next item may be accepted in the strobe cycle.
// Synchronous active-high reset clears control and triangle_count; the table is not cleared.
module triangle_zone_coverage_test #(
   parameter int NUM_TRIANGLES = 16,
   parameter int GRID_BITS     = 12
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_type,
   input  logic [tzc_pkg::SLOT_W-1:0]    req_slot_index,
   input  logic signed [tzc_pkg::COORD_W-1:0] req_first_x,
   input  logic signed [tzc_pkg::COORD_W-1:0] req_first_y,
   input  logic signed [tzc_pkg::COORD_W-1:0] req_second_x,
   input  logic signed [tzc_pkg::COORD_W-1:0] req_second_y,
   input  logic signed [tzc_pkg::COORD_W-1:0] req_third_x,
   input  logic signed [tzc_pkg::COORD_W-1:0] req_third_y,
   input  logic [tzc_pkg::GRID_W-1:0]    req_point_x,
   input  logic [tzc_pkg::GRID_W-1:0]    req_point_y,
   output logic                          rsp_valid,
   output logic                          rsp_inside_res,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [tzc_pkg::CNT_W-1:0]     csr_triangle_count
);

   localparam int ADDR_W = (NUM_TRIANGLES > 1) ? $clog2(NUM_TRIANGLES) : 1;
   localparam int CW     = tzc_pkg::CNT_W;
   localparam int XW     = tzc_pkg::COORD_W;
   localparam logic [XW-1:0] GRID_MASK = XW'((32'd1 << GRID_BITS) - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_DRAIN
   } state_type;

   state_type                state_ff;
   logic [CW-1:0]            count_ff;
   logic [CW-1:0]            n_ff;
   logic [CW-1:0]            iss_cnt_ff;
   logic [XW-1:0]            px_ff;
   logic [XW-1:0]            py_ff;
   logic                     hit_acc_ff;
   logic                     rd_vld_ff;
   logic                     rsp_valid_ff;
   logic                     rsp_inside_ff;

   logic                     accept;
   logic                     load_go;
   logic                     query_go;
   logic [CW-1:0]            n_sat;
   logic                     rd_en;
   tzc_pkg::row_type         wr_row;
   tzc_pkg::row_type         rd_row;
   tzc_pkg::test_status_type status;

   assign accept   = start && !busy;
   assign load_go  = accept && (req_type == tzc_pkg::REQ_LOAD)
                  && (32'(req_slot_index) < NUM_TRIANGLES);
   assign query_go = accept && (req_type == tzc_pkg::REQ_QUERY);
   assign n_sat    = (32'(count_ff) > NUM_TRIANGLES) ? CW'(NUM_TRIANGLES) : count_ff;
   assign rd_en    = (state_ff == ST_ISSUE);

   always_comb begin
      wr_row.first.x  = req_first_x;
      wr_row.first.y  = req_first_y;
      wr_row.second.x = req_second_x;
      wr_row.second.y = req_second_y;
      wr_row.third.x  = req_third_x;
      wr_row.third.y  = req_third_y;
   end

   tzc_table #(
      .DEPTH  (NUM_TRIANGLES),
      .ADDR_W (ADDR_W)
   ) u_table (
      .clock   (clock),
      .wr_en   (load_go),
      .wr_addr (ADDR_W'(req_slot_index)),
      .wr_data (wr_row),
      .rd_en   (rd_en),
      .rd_addr (ADDR_W'(iss_cnt_ff)),
      .rd_data (rd_row)
   );

   tzc_edge_test u_edge_test (
      .clock    (clock),
      .reset    (reset),
      .in_valid (rd_vld_ff),
      .in_row   (rd_row),
      .px       (px_ff),
      .py       (py_ff),
      .status   (status)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         hit_acc_ff   <= 1'b0;
      end else begin
         rsp_valid_ff <= (state_ff == ST_DRAIN) && !status.busy;
         rd_vld_ff    <= rd_en;
         if (csr_valid && csr_ready) begin
            count_ff <= csr_triangle_count;
         end
         if (query_go) begin
            hit_acc_ff <= 1'b0;
         end else if (status.hit_vld && status.hit) begin
            hit_acc_ff <= 1'b1;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (query_go) begin
                  n_ff       <= n_sat;
                  iss_cnt_ff <= '0;
                  px_ff      <= XW'(req_point_x) & GRID_MASK;
                  py_ff      <= XW'(req_point_y) & GRID_MASK;
                  state_ff   <= (n_sat == '0) ? ST_DRAIN : ST_ISSUE;
               end
            end
            ST_ISSUE: begin
               iss_cnt_ff <= iss_cnt_ff + CW'(1);
               if (iss_cnt_ff + CW'(1) == n_ff) begin
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               // wait until the last triangle has left the pipeline
               if (!status.busy) begin
                  rsp_inside_ff <= hit_acc_ff;
                  state_ff      <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign busy           = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_inside_res = rsp_inside_ff;
   assign csr_ready      = 1'b1;

endmodule

### hw/rtl/tzc_table.sv
`timescale 1ns / 1ps

module tzc_table #(
   parameter int DEPTH  = 16,
   parameter int ADDR_W = 4
) (
   input  logic                    clock,
   input  logic                    wr_en,
   input  logic [ADDR_W-1:0]       wr_addr,
   input  tzc_pkg::row_type        wr_data,
   input  logic                    rd_en,
   input  logic [ADDR_W-1:0]       rd_addr,
   output tzc_pkg::row_type        rd_data
);

   tzc_pkg::row_type mem [DEPTH];
   tzc_pkg::row_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/tzc_edge_test.sv
`timescale 1ns / 1ps

module tzc_edge_test (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  tzc_pkg::row_type              in_row,
   input  logic [tzc_pkg::COORD_W-1:0]   px,
   input  logic [tzc_pkg::COORD_W-1:0]   py,
   output tzc_pkg::test_status_type      status
);

   localparam int DW = tzc_pkg::DIFF_W;
   localparam int PW = tzc_pkg::PDIFF_W;
   localparam int MW = tzc_pkg::PROD_W;
   localparam int SW = tzc_pkg::SUM_W;

   // stage 1: coordinate differences
   logic signed [DW-1:0] x1e, y1e, x2e, y2e, x3e, y3e;
   logic signed [PW-1:0] pxe, pye, x3p, y3p;
   logic signed [DW-1:0] dx13_in, dy23_in, dx32_in, dy13_in, dy31_in;
   logic signed [PW-1:0] pxd_in, pyd_in;
   logic signed [DW-1:0] dx13_ff, dy23_ff, dx32_ff, dy13_ff, dy31_ff;
   logic signed [PW-1:0] pxd_ff, pyd_ff;
   logic                 s1_vld_ff;

   // stage 2: products
   logic signed [MW-1:0] pd1_in, pd2_in, pa1_in, pa2_in, pb1_in, pb2_in;
   logic signed [MW-1:0] pd1_ff, pd2_ff, pa1_ff, pa2_ff, pb1_ff, pb2_ff;
   logic                 s2_vld_ff;

   // stage 3: doubled area and edge numerators
   logic signed [SW-1:0] d_in, a_in, b_in;
   logic signed [SW-1:0] d_ff, a_ff, b_ff;
   logic                 s3_vld_ff;

   // stage 4: sign tests
   logic signed [SW-1:0] e_val;
   logic                 d_pos, d_neg, a_le0, b_le0, e_le0;
   logic                 hit_in;
   logic                 hit_ff;
   logic                 s4_vld_ff;

   always_comb begin
      x1e = DW'(in_row.first.x);
      y1e = DW'(in_row.first.y);
      x2e = DW'(in_row.second.x);
      y2e = DW'(in_row.second.y);
      x3e = DW'(in_row.third.x);
      y3e = DW'(in_row.third.y);
      pxe = $signed({2'b00, px});
      pye = $signed({2'b00, py});
      x3p = PW'(in_row.third.x);
      y3p = PW'(in_row.third.y);

      dx13_in = x1e - x3e;
      dy23_in = y2e - y3e;
      dx32_in = x3e - x2e;
      dy13_in = y1e - y3e;
      dy31_in = y3e - y1e;
      pxd_in  = pxe - x3p;
      pyd_in  = pye - y3p;
   end

   always_comb begin
      pd1_in = dy23_ff * dx13_ff;
      pd2_in = dx32_ff * dy13_ff;
      pa1_in = dy23_ff * pxd_ff;
      pa2_in = dx32_ff * pyd_ff;
      pb1_in = dy31_ff * pxd_ff;
      pb2_in = dx13_ff * pyd_ff;
   end

   always_comb begin
      d_in = SW'(pd1_ff) + SW'(pd2_ff);
      a_in = SW'(pa1_ff) + SW'(pa2_ff);
      b_in = SW'(pb1_ff) + SW'(pb2_ff);
   end

   // for negative area every inequality flips instead of negating
   always_comb begin
      e_val  = d_ff - a_ff - b_ff;
      d_neg  = d_ff[SW-1];
      d_pos  = !d_ff[SW-1] && (d_ff != '0);
      a_le0  = a_ff[SW-1] || (a_ff == '0);
      b_le0  = b_ff[SW-1] || (b_ff == '0);
      e_le0  = e_val[SW-1] || (e_val == '0);
      hit_in = (d_pos && !a_ff[SW-1] && !b_ff[SW-1] && !e_val[SW-1])
            || (d_neg && a_le0 && b_le0 && e_le0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= in_valid;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
         s4_vld_ff <= s3_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      dx13_ff <= dx13_in;
      dy23_ff <= dy23_in;
      dx32_ff <= dx32_in;
      dy13_ff <= dy13_in;
      dy31_ff <= dy31_in;
      pxd_ff  <= pxd_in;
      pyd_ff  <= pyd_in;
      pd1_ff  <= pd1_in;
      pd2_ff  <= pd2_in;
      pa1_ff  <= pa1_in;
      pa2_ff  <= pa2_in;
      pb1_ff  <= pb1_in;
      pb2_ff  <= pb2_in;
      d_ff    <= d_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      hit_ff  <= hit_in;
   end

   assign status.busy    = in_valid || s1_vld_ff || s2_vld_ff || s3_vld_ff || s4_vld_ff;
   assign status.hit_vld = s4_vld_ff;
   assign status.hit     = hit_ff;

endmodule

### hw/rtl/tzc_checker.sv
`timescale 1ns / 1ps

module tzc_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic req_type,
   input logic rsp_valid
);

   // a result strobe lasts exactly one cycle
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("rsp_valid held longer than one cycle");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while busy");

   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_type == tzc_pkg::REQ_QUERY) |=> busy)
      else $error("query transfer did not raise busy");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_type == tzc_pkg::REQ_LOAD) |=> !busy)
      else $error("load transfer raised busy");

   // every query ends with exactly its result
   a_done_result: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid)
      else $error("busy dropped without a result");

endmodule

bind triangle_zone_coverage_test tzc_checker u_tzc_checker (.*);
